/* src/dss_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dss_pkg
// Shared widths, codes, byte constants and decode helpers for the
// duration string parser.
// ----------------------------------------------------------------------------
package dss_pkg;

   localparam int NUM_W  = 31;   // magnitude of any legal value, <= 2^31-1
   localparam int MUL_W  = 25;   // widest unit multiplier (365 days)
   localparam int PROD_W = NUM_W + MUL_W;

   localparam int ONE_DAY = 24 * 60 * 60;

   // parse phases
   localparam logic [1:0] PH_LEAD = 2'd0;
   localparam logic [1:0] PH_PRE  = 2'd1;
   localparam logic [1:0] PH_DIG  = 2'd2;
   localparam logic [1:0] PH_POST = 2'd3;

   // result status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_BAD   = 2'd2;
   localparam logic [1:0] ST_RANGE = 2'd3;

   // byte codes
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_9     = 8'h39;
   localparam logic [7:0] CH_UC_A  = 8'h41;
   localparam logic [7:0] CH_UC_Z  = 8'h5A;
   localparam logic [7:0] CH_LC_A  = 8'h61;
   localparam logic [7:0] CH_LC_Z  = 8'h7A;
   localparam logic [7:0] CH_UC_Y  = 8'h59;
   localparam logic [7:0] CH_UC_M  = 8'h4D;
   localparam logic [7:0] CH_UC_W  = 8'h57;
   localparam logic [7:0] CH_LC_W  = 8'h77;
   localparam logic [7:0] CH_UC_D  = 8'h44;
   localparam logic [7:0] CH_LC_D  = 8'h64;
   localparam logic [7:0] CH_LC_H  = 8'h68;
   localparam logic [7:0] CH_LC_M  = 8'h6D;
   localparam logic [7:0] CH_LC_S  = 8'h73;

   // Segment handed from the scanner to the result stage.
   typedef struct packed {
      logic [NUM_W-1:0]  total;  // sum of segments already resolved
      logic [PROD_W-1:0] prod;   // last segment value times its unit
      logic              pend;   // prod still has to be added
      logic              neg;
      logic [1:0]        err;
      logic              empty;
   } dss_close_type;

   function automatic logic is_space(input logic [7:0] c);
      return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= CH_UC_A && c <= CH_UC_Z) || (c >= CH_LC_A && c <= CH_LC_Z);
   endfunction

   // Seconds per unit letter, zero if the byte is not a unit letter.
   function automatic logic [MUL_W-1:0] unit_mul(input logic [7:0] c);
      logic [MUL_W-1:0] m;
      unique case (c)
         CH_UC_Y:          m = MUL_W'(ONE_DAY * 365);
         CH_UC_M:          m = MUL_W'(ONE_DAY * 31);
         CH_UC_W, CH_LC_W: m = MUL_W'(ONE_DAY * 7);
         CH_UC_D, CH_LC_D: m = MUL_W'(ONE_DAY);
         CH_LC_H:          m = MUL_W'(60 * 60);
         CH_LC_M:          m = MUL_W'(60);
         CH_LC_S:          m = MUL_W'(1);
         default:          m = '0;
      endcase
      return m;
   endfunction

endpackage

/* src/dss_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dss_req_if
// Byte channel into the parser: one character and an end-of-string mark.
// ----------------------------------------------------------------------------
interface dss_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_in;
   logic       last;

   modport source (output valid, output char_in, output last, input ready);
   modport sink   (input valid, input char_in, input last, output ready);
endinterface

/* src/dss_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dss_rsp_if
// Result channel out of the parser: signed seconds and a status code.
// ----------------------------------------------------------------------------
interface dss_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [31:0] seconds;
   logic [1:0]        status;

   modport source (output valid, output seconds, output status, input ready);
   modport sink   (input valid, input seconds, input status, output ready);
endinterface

/* src/duration_string_to_seconds_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// duration_string_to_seconds_core
// Parses a duration string such as "-1d 2h30m5" into signed seconds.
//
// Usage: bytes of a string arrive on req (char_in, last), one item per
// cycle while req.ready is high; last marks the final byte. For each
// string one item appears on rsp with seconds and status (0 ok, 1 empty,
// 2 bad text, 3 out of range); seconds is 0 whenever status is not ok.
// Throughput: one byte per cycle while req.ready is high, strings back to
// back with no gap. A finished string waits in a hold stage, then in the
// result register. A unit letter multiplies its segment into a product
// register; the add into the running total happens in the following
// cycle, and the final segment is added and signed in the result stage.
// Stall: the result register and the stage before it each hold one
// string; req.ready drops only while both are full and rsp.ready is low.
// Reset (synchronous, active high) clears the parse state and both
// valid flags.
// ----------------------------------------------------------------------------
module duration_string_to_seconds_core
   import dss_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   dss_req_if.sink   req,
   dss_rsp_if.source rsp
);

   logic          accept;
   logic          out_free;
   logic          close_valid;
   dss_close_type close;

   logic          fin_valid_ff, fin_valid_in;
   dss_close_type fin_ff,       fin_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] seconds_ff,   seconds_in;
   logic [1:0]         status_ff,    status_in;

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign req.ready = !fin_valid_ff || out_free;
   assign accept    = req.valid && req.ready;

   dss_scan u_scan (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .char_in     (req.char_in),
      .last        (req.last),
      .close_valid (close_valid),
      .close       (close)
   );

   // hold a finished string until the result register frees up
   always_comb begin
      fin_valid_in = fin_valid_ff;
      fin_in       = fin_ff;
      if (close_valid) begin
         fin_valid_in = 1'b1;
         fin_in       = close;
      end else if (out_free) begin
         fin_valid_in = 1'b0;
      end
   end

   // add the last segment, check range, apply the sign
   logic [NUM_W:0]   fin_sum;
   logic             fin_over;
   logic [NUM_W-1:0] fin_mag;

   assign fin_sum  = {1'b0, fin_ff.total} + {1'b0, fin_ff.prod[NUM_W-1:0]};
   assign fin_over = fin_ff.pend &&
                     ((|fin_ff.prod[PROD_W-1:NUM_W]) || fin_sum[NUM_W]);
   assign fin_mag  = fin_ff.pend ? fin_sum[NUM_W-1:0] : fin_ff.total;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      seconds_in   = seconds_ff;
      status_in    = status_ff;
      if (out_free) begin
         rsp_valid_in = fin_valid_ff;
         seconds_in   = '0;
         if (fin_ff.err != ST_OK) begin
            status_in = fin_ff.err;
         end else if (fin_ff.empty) begin
            status_in = ST_EMPTY;
         end else if (fin_over) begin
            status_in = ST_RANGE;
         end else begin
            status_in  = ST_OK;
            seconds_in = fin_ff.neg ? -$signed({1'b0, fin_mag})
                                    :  $signed({1'b0, fin_mag});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fin_valid_ff <= fin_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      fin_ff     <= fin_in;
      seconds_ff <= seconds_in;
      status_ff  <= status_in;
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.seconds = seconds_ff;
   assign rsp.status  = status_ff;

endmodule

/* src/dss_scan.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dss_scan
// Per-byte parse state. A closed segment is multiplied by its unit into a
// pending product register and added to the running total next cycle.
// ----------------------------------------------------------------------------
module dss_scan
   import dss_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          accept,
   input  logic [7:0]    char_in,
   input  logic          last,
   output logic          close_valid,
   output dss_close_type close
);

   logic [NUM_W-1:0]  total_ff,  total_in;
   logic [NUM_W-1:0]  number_ff, number_in;
   logic              neg_ff,    neg_in;
   logic [1:0]        phase_ff,  phase_in;
   logic [1:0]        err_ff,    err_in;
   logic              pend_ff,   pend_in;
   logic [PROD_W-1:0] prod_ff,   prod_in;

   // resolve the product left by the previous cycle
   logic [NUM_W:0]    res_sum;
   logic              res_err;
   logic [NUM_W-1:0]  total_res;
   logic [1:0]        err_eff;

   assign res_sum   = {1'b0, total_ff} + {1'b0, prod_ff[NUM_W-1:0]};
   assign res_err   = pend_ff && ((|prod_ff[PROD_W-1:NUM_W]) || res_sum[NUM_W]);
   assign total_res = (pend_ff && !res_err) ? res_sum[NUM_W-1:0] : total_ff;
   assign err_eff   = (err_ff != ST_OK) ? err_ff : (res_err ? ST_RANGE : ST_OK);

   // byte decode
   logic [NUM_W+3:0]  digit_sum;
   logic [MUL_W-1:0]  mul;
   logic [NUM_W-1:0]  number_nx;
   logic              neg_nx;
   logic [1:0]        phase_nx;
   logic [1:0]        err_nx;
   logic              unit_close;
   logic              final_close;
   logic [PROD_W-1:0] prod_nx;

   assign digit_sum = {1'b0, number_ff, 3'b000} + {3'b000, number_ff, 1'b0}
                    + (NUM_W+4)'(char_in - CH_0);
   assign mul = unit_mul(char_in);

   always_comb begin
      number_nx  = number_ff;
      neg_nx     = neg_ff;
      phase_nx   = phase_ff;
      err_nx     = err_eff;
      unit_close = 1'b0;
      if (err_eff == ST_OK) begin
         if (is_space(char_in)) begin
            if (phase_ff == PH_DIG) begin
               phase_nx = PH_POST;
            end
         end else if (char_in >= CH_0 && char_in <= CH_9) begin
            if (phase_ff == PH_POST) begin
               err_nx = ST_BAD;
            end else if (|digit_sum[NUM_W+3:NUM_W]) begin
               err_nx = ST_RANGE;
            end else begin
               number_nx = digit_sum[NUM_W-1:0];
               phase_nx  = PH_DIG;
            end
         end else if (char_in == CH_MINUS && phase_ff == PH_LEAD) begin
            neg_nx   = 1'b1;
            phase_nx = PH_PRE;
         end else if (is_alpha(char_in)) begin
            if (mul == '0) begin
               err_nx = ST_BAD;
            end else begin
               // an empty segment adds nothing
               unit_close = (phase_ff == PH_DIG) || (phase_ff == PH_POST);
               number_nx  = '0;
               phase_nx   = PH_PRE;
            end
         end else begin
            err_nx = ST_BAD;
         end
      end
   end

   // trailing number on the final byte counts as seconds
   assign final_close = last && (err_nx == ST_OK) &&
                        ((phase_nx == PH_DIG) || (phase_nx == PH_POST));
   assign prod_nx = final_close ? {{MUL_W{1'b0}}, number_nx}
                                : {{MUL_W{1'b0}}, number_ff} * {{NUM_W{1'b0}}, mul};

   assign close_valid = accept && last;
   always_comb begin
      close.total = total_res;
      close.prod  = prod_nx;
      close.pend  = unit_close || final_close;
      close.neg   = neg_nx;
      close.err   = err_nx;
      close.empty = (err_nx == ST_OK) && (phase_nx == PH_LEAD);
   end

   always_comb begin
      total_in  = total_res;
      number_in = number_ff;
      neg_in    = neg_ff;
      phase_in  = phase_ff;
      err_in    = err_eff;
      pend_in   = 1'b0;
      prod_in   = prod_nx;
      if (accept) begin
         if (last) begin
            // string done: the result stage takes it, start over
            total_in  = '0;
            number_in = '0;
            neg_in    = 1'b0;
            phase_in  = PH_LEAD;
            err_in    = ST_OK;
         end else begin
            number_in = number_nx;
            neg_in    = neg_nx;
            phase_in  = phase_nx;
            err_in    = err_nx;
            pend_in   = unit_close;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff  <= '0;
         number_ff <= '0;
         neg_ff    <= 1'b0;
         phase_ff  <= PH_LEAD;
         err_ff    <= ST_OK;
         pend_ff   <= 1'b0;
      end else begin
         total_ff  <= total_in;
         number_ff <= number_in;
         neg_ff    <= neg_in;
         phase_ff  <= phase_in;
         err_ff    <= err_in;
         pend_ff   <= pend_in;
      end
      prod_ff <= prod_in;
   end

endmodule
